@@ sv/sft_pkg.sv @@
// shared types and constants for the sorted fitness table
`timescale 1ns / 1ps

package sft_pkg;

  // default table depth
  localparam int DEPTH_DEF = 64;

  // key written by insert-last (most negative q16.16 value)
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;

  // request codes
  typedef enum logic [1:0] {
    REQ_INS_SORT = 2'd0,
    REQ_INS_LAST = 2'd1,
    REQ_REM_POS  = 2'd2,
    REQ_REM_LAST = 2'd3
  } req_t;

  // status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_CLAMP = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_SCAN,
    ST_INS_WR,
    ST_REM_TAKE,
    ST_REM_SHIFT,
    ST_FIN
  } state_t;

  // one stored entry
  typedef struct packed {
    logic signed [31:0] key;
    logic [7:0]         handle;
  } entry_t;

  // one result beat from the sequencer
  typedef struct packed {
    logic [7:0]         handle;
    logic signed [31:0] key;
    status_t            status;
    logic [6:0]         fill_count;
  } res_t;

endpackage

@@ sv/sft_store.sv @@
// entry memory: one write port, one registered read port
`timescale 1ns / 1ps

module sft_store #(
  parameter int DEPTH = sft_pkg::DEPTH_DEF,
  parameter int IW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [IW-1:0]   wr_addr,
  input  sft_pkg::entry_t wr_data,
  input  logic [IW-1:0]   rd_addr,
  output sft_pkg::entry_t rd_data
);

  sft_pkg::entry_t mem [DEPTH];
  sft_pkg::entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/sft_seq.sv @@
// request sequencer with the shared key compare and index counter
`timescale 1ns / 1ps

module sft_seq #(
  parameter int DEPTH = sft_pkg::DEPTH_DEF,
  parameter int IW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  // input beat
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic signed [31:0] in_key,
  input  logic [7:0]         in_handle,
  input  logic [5:0]         in_position,
  // memory side
  output logic               wr_en,
  output logic [IW-1:0]      wr_addr,
  output sft_pkg::entry_t    wr_data,
  output logic [IW-1:0]      rd_addr,
  input  sft_pkg::entry_t    rd_data,
  // result side
  output logic               res_valid,
  input  logic               res_take,
  output sft_pkg::res_t      res
);

  localparam int PW = (CW > 6) ? CW : 6;

  sft_pkg::state_t    state_r, state_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic [7:0]         hdl_r, hdl_nxt;
  sft_pkg::entry_t    take_r, take_nxt;
  sft_pkg::status_t   stat_r, stat_nxt;

  logic               full;
  logic               clamp;
  logic [IW-1:0]      rem_pos;
  logic               key_ge;
  logic [CW-1:0]      idx_ext;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sft_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    key_r  <= key_nxt;
    hdl_r  <= hdl_nxt;
    take_r <= take_nxt;
    stat_r <= stat_nxt;
  end

  // request decode helpers
  assign full    = (cnt_r == CW'(DEPTH));
  assign clamp   = (PW'(in_position) >= PW'(cnt_r));
  assign rem_pos = clamp ? IW'(cnt_r - CW'(1)) : IW'(PW'(in_position));
  assign idx_ext = CW'(idx_r);

  // shared compare unit: new key against the entry just read
  assign key_ge  = ($signed(key_r) >= $signed(rd_data.key));

  // next state and outputs
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    key_nxt   = key_r;
    hdl_nxt   = hdl_r;
    take_nxt  = take_r;
    stat_nxt  = stat_r;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = rd_data;
    rd_addr   = idx_r;
    in_stall  = 1'b1;
    res_valid = 1'b0;

    case (state_r)
      sft_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          take_nxt = '0;
          stat_nxt = sft_pkg::STAT_OK;
          hdl_nxt  = in_handle;
          case (in_req_type)
            sft_pkg::REQ_INS_SORT: begin
              key_nxt = in_key;
              idx_nxt = IW'(cnt_r);
              rd_addr = IW'(cnt_r - CW'(1));
              if (full) begin
                stat_nxt  = sft_pkg::STAT_FULL;
                state_nxt = sft_pkg::ST_FIN;
              end else if (cnt_r == '0) begin
                state_nxt = sft_pkg::ST_INS_WR;
              end else begin
                state_nxt = sft_pkg::ST_INS_SCAN;
              end
            end
            sft_pkg::REQ_INS_LAST: begin
              key_nxt = sft_pkg::KEY_MIN;
              idx_nxt = IW'(cnt_r);
              if (full) begin
                stat_nxt  = sft_pkg::STAT_FULL;
                state_nxt = sft_pkg::ST_FIN;
              end else begin
                state_nxt = sft_pkg::ST_INS_WR;
              end
            end
            default: begin
              // both removals: pick the slot, then read it
              if (cnt_r == '0) begin
                stat_nxt  = sft_pkg::STAT_EMPTY;
                state_nxt = sft_pkg::ST_FIN;
              end else if (in_req_type == sft_pkg::REQ_REM_POS) begin
                idx_nxt   = rem_pos;
                rd_addr   = rem_pos;
                stat_nxt  = clamp ? sft_pkg::STAT_CLAMP : sft_pkg::STAT_OK;
                state_nxt = sft_pkg::ST_REM_TAKE;
              end else begin
                idx_nxt   = IW'(cnt_r - CW'(1));
                rd_addr   = IW'(cnt_r - CW'(1));
                state_nxt = sft_pkg::ST_REM_TAKE;
              end
            end
          endcase
        end
      end

      // walk down from the tail, moving smaller-or-equal keys up one slot
      sft_pkg::ST_INS_SCAN: begin
        rd_addr = idx_r - IW'(2);
        if (key_ge) begin
          wr_en   = 1'b1;
          wr_addr = idx_r;
          wr_data = rd_data;
          idx_nxt = idx_r - IW'(1);
          if (idx_r == IW'(1)) begin
            state_nxt = sft_pkg::ST_INS_WR;
          end
        end else begin
          state_nxt = sft_pkg::ST_INS_WR;
        end
      end

      // drop the new entry into the freed slot
      sft_pkg::ST_INS_WR: begin
        wr_en          = 1'b1;
        wr_addr        = idx_r;
        wr_data.key    = key_r;
        wr_data.handle = hdl_r;
        cnt_nxt        = cnt_r + CW'(1);
        state_nxt      = sft_pkg::ST_FIN;
      end

      // capture the removed entry, start closing the gap
      sft_pkg::ST_REM_TAKE: begin
        take_nxt = rd_data;
        rd_addr  = idx_r + IW'(1);
        if (idx_ext + CW'(1) < cnt_r) begin
          state_nxt = sft_pkg::ST_REM_SHIFT;
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = sft_pkg::ST_FIN;
        end
      end

      // move each following entry down one slot
      sft_pkg::ST_REM_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = rd_data;
        idx_nxt = idx_r + IW'(1);
        rd_addr = idx_r + IW'(2);
        if (idx_ext + CW'(2) >= cnt_r) begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = sft_pkg::ST_FIN;
        end
      end

      // hand the result to the output register
      sft_pkg::ST_FIN: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = sft_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = sft_pkg::ST_IDLE;
      end
    endcase
  end

  // result beat contents
  always_comb begin
    res.handle     = take_r.handle;
    res.key        = take_r.key;
    res.status     = stat_r;
    res.fill_count = 7'(cnt_r);
  end

endmodule

@@ sv/sorted_fitness_table_unit.sv @@
// sorted fitness table: top level with output register
// flow: sorted insert moves smaller-or-equal keys up one slot from the tail, then writes the new
//   entry; insert-last writes at the tail; remove reads the slot, then moves later entries down;
//   full or empty errors go straight to the result; out_valid rises the cycle after it is taken
// throughput: one request at a time; the next is taken once the result is in the output register
// reset: synchronous active-low clears the entry count and handshake state, not the entry memory
`timescale 1ns / 1ps

module sorted_fitness_table_unit #(
  parameter int DEPTH = sft_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic signed [31:0] in_key,
  input  logic [7:0]         in_handle,
  input  logic [5:0]         in_position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_handle,
  output logic signed [31:0] out_key,
  output logic [1:0]         out_status,
  output logic [6:0]         out_fill_count
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  sft_pkg::entry_t wr_data;
  logic [IW-1:0]   rd_addr;
  sft_pkg::entry_t rd_data;
  logic            res_valid;
  logic            res_take;
  sft_pkg::res_t   res;

  logic            out_valid_r, out_valid_nxt;
  sft_pkg::res_t   out_res_r;

  sft_seq #(
    .DEPTH(DEPTH),
    .IW   (IW),
    .CW   (CW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req_type(in_req_type),
    .in_key     (in_key),
    .in_handle  (in_handle),
    .in_position(in_position),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

  sft_store #(
    .DEPTH(DEPTH),
    .IW   (IW)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // output register loads when empty or when its beat is leaving
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_handle     = out_res_r.handle;
  assign out_key        = out_res_r.key;
  assign out_status     = out_res_r.status;
  assign out_fill_count = out_res_r.fill_count;

`ifndef SYNTH
  // a taken request always keeps the sequencer busy after the accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("sequencer took a request and was not busy next cycle");

  // a handed-over result shows up at the output
  a_res_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_take |=> out_valid)
    else $error("result taken but output register empty");

  // dropped inserts and empty removals carry no entry
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == sft_pkg::STAT_FULL || out_status == sft_pkg::STAT_EMPTY)
      |-> out_key == '0 && out_handle == '0)
    else $error("error result carries a non-zero entry");

  // a result never stands in the sequencer while the output is free
  a_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !out_valid |-> res_take)
    else $error("result held back with output register empty");
`endif

endmodule
